/* rtl/core/ppurp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPU register port package
// Shared constants for the CPU register port: actions, register numbers,
// memory depths and fixed values of the register behavior.
// ----------------------------------------------------------------------------
package ppurp_pkg;

  // Actions carried by one input item.
  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_VBL   = 3'd2;
  localparam logic [2:0] ACT_POLL  = 3'd3;
  localparam logic [2:0] ACT_LOAD  = 3'd4;
  localparam logic [2:0] ACT_HIT   = 3'd5;

  // Register numbers.
  localparam logic [2:0] REG_CTRL1  = 3'd0;
  localparam logic [2:0] REG_CTRL2  = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SPADDR = 3'd3;
  localparam logic [2:0] REG_SPDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_VADDR  = 3'd6;
  localparam logic [2:0] REG_VDATA  = 3'd7;

  // Default memory depths (powers of two).
  localparam int VRAM_DEPTH_DEF = 16384;
  localparam int OAM_DEPTH_DEF  = 256;

  // Fixed values.
  localparam logic [15:0] VADDR_RESET  = 16'h2000;
  localparam logic [15:0] VADDR_LIMIT  = 16'h4000;
  localparam logic [15:0] VADDR_STEP_L = 16'd32;
  localparam logic [15:0] VADDR_STEP_S = 16'd1;
  localparam logic [7:0]  VSCROLL_MAX  = 8'd239;

endpackage

/* rtl/core/ppu_cpu_register_port.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPU CPU register port
// Register reads and writes, vblank and hit events and direct loads for a
// tile video unit, with its video memory and sprite memory.
// ----------------------------------------------------------------------------
// The result of an item is shown with out_valid high for a single cycle,
// in the cycle after the item is accepted.
// Throughput: one item per cycle. busy is never raised; each item makes at
// most one write to each memory at its accept edge and updates the pointers.
// Reset: synchronous, active low. Pointers and control registers take their
// reset values at once; both memories hold undefined data until written.
// The receiver takes every result in the cycle it is shown.
// ----------------------------------------------------------------------------
module ppu_cpu_register_port #(
  parameter int VRAM_DEPTH = ppurp_pkg::VRAM_DEPTH_DEF,
  parameter int OAM_DEPTH  = ppurp_pkg::OAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_reg_sel,
  input  logic [7:0]  in_wdata,
  input  logic [13:0] in_load_addr,
  input  logic        in_flag_in,
  output logic        out_valid,
  output logic [7:0]  out_rdata,
  output logic        out_irq_pending
);

  // Memory index widths. Both depths are powers of two, so an address
  // modulo the depth is just its low bits.
  localparam int VA_W = $clog2(VRAM_DEPTH);
  localparam int OA_W = $clog2(OAM_DEPTH);

  // Where the read byte of the item in the output stage comes from.
  typedef enum logic [1:0] {
    SRC_REG,
    SRC_VRAM,
    SRC_OAM
  } rd_src_t;

  // Memories. Read data is registered every cycle at the current pointer.
  logic [7:0] vram_mem [VRAM_DEPTH];
  logic [7:0] oam_mem  [OAM_DEPTH];
  logic [7:0] vram_q_r;
  logic [7:0] oam_q_r;

  // Port state.
  logic [15:0] video_addr_r,   video_addr_nxt;
  logic [7:0]  sprite_addr_r,  sprite_addr_nxt;
  logic [7:0]  scroll_count_r, scroll_count_nxt;
  logic [7:0]  horiz_scroll_r, horiz_scroll_nxt;
  logic [7:0]  vert_scroll_r,  vert_scroll_nxt;
  logic [7:0]  ctrl_one_r,     ctrl_one_nxt;
  logic [7:0]  ctrl_two_r,     ctrl_two_nxt;
  logic [7:0]  status_r,       status_nxt;
  logic        vblank_r,       vblank_nxt;
  logic        hit_r,          hit_nxt;

  // Output stage.
  logic        out_valid_r;
  logic [7:0]  rdata_r,        rdata_nxt;
  logic        irq_r,          irq_nxt;
  rd_src_t     src_r,          src_nxt;

  // Memory write controls.
  logic            vram_we;
  logic [VA_W-1:0] vram_waddr;
  logic            oam_we;

  logic        accept;
  logic        vaddr_ok;
  logic [15:0] vaddr_step;
  logic [7:0]  status_set;

  // Every item completes in one pass, so the port is always ready.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Data accesses at or above the top of the video address space are skipped.
  assign vaddr_ok   = (video_addr_r < ppurp_pkg::VADDR_LIMIT);
  assign vaddr_step = ctrl_one_r[2] ? ppurp_pkg::VADDR_STEP_L : ppurp_pkg::VADDR_STEP_S;
  // A status read always reports bit 7 set.
  assign status_set = status_r | 8'h80;

  always_comb begin
    video_addr_nxt   = video_addr_r;
    sprite_addr_nxt  = sprite_addr_r;
    scroll_count_nxt = scroll_count_r;
    horiz_scroll_nxt = horiz_scroll_r;
    vert_scroll_nxt  = vert_scroll_r;
    ctrl_one_nxt     = ctrl_one_r;
    ctrl_two_nxt     = ctrl_two_r;
    status_nxt       = status_r;
    vblank_nxt       = vblank_r;
    hit_nxt          = hit_r;
    rdata_nxt        = 8'd0;
    irq_nxt          = 1'b0;
    src_nxt          = SRC_REG;
    vram_we          = 1'b0;
    vram_waddr       = video_addr_r[VA_W-1:0];
    oam_we           = 1'b0;

    if (accept) begin
      unique case (in_action)
        ppurp_pkg::ACT_WRITE: begin
          unique case (in_reg_sel)
            ppurp_pkg::REG_CTRL1:  ctrl_one_nxt    = in_wdata;
            ppurp_pkg::REG_CTRL2:  ctrl_two_nxt    = in_wdata;
            ppurp_pkg::REG_STATUS: status_nxt      = in_wdata;
            ppurp_pkg::REG_SPADDR: sprite_addr_nxt = in_wdata;
            ppurp_pkg::REG_SPDATA: begin
              oam_we          = 1'b1;
              sprite_addr_nxt = sprite_addr_r + 8'd1;
            end
            ppurp_pkg::REG_SCROLL: begin
              // First write sets horizontal scroll, second sets vertical
              // scroll unless the value is past the last visible line.
              if (scroll_count_r == 8'd0) begin
                horiz_scroll_nxt = in_wdata;
              end else if (scroll_count_r == 8'd1 && in_wdata <= ppurp_pkg::VSCROLL_MAX) begin
                vert_scroll_nxt = in_wdata;
              end
              scroll_count_nxt = scroll_count_r + 8'd1;
            end
            ppurp_pkg::REG_VADDR: video_addr_nxt = {video_addr_r[7:0], in_wdata};
            ppurp_pkg::REG_VDATA: begin
              if (vaddr_ok) begin
                vram_we        = 1'b1;
                video_addr_nxt = video_addr_r + vaddr_step;
              end
            end
            default: ;
          endcase
        end
        ppurp_pkg::ACT_READ: begin
          unique case (in_reg_sel)
            ppurp_pkg::REG_CTRL1:  rdata_nxt = ctrl_one_r;
            ppurp_pkg::REG_CTRL2:  rdata_nxt = ctrl_two_r;
            ppurp_pkg::REG_STATUS: begin
              rdata_nxt = status_set;
              // Bit 6 is cleared if it was set, and else is set when the hit flag is high.
              if (status_set[6]) begin
                status_nxt = status_set & 8'hBF;
              end else if (hit_r) begin
                status_nxt = status_set | 8'h40;
              end else begin
                status_nxt = status_set;
              end
              scroll_count_nxt = 8'd0;
              video_addr_nxt   = 16'd0;
            end
            ppurp_pkg::REG_SPADDR: rdata_nxt = sprite_addr_r;
            ppurp_pkg::REG_SPDATA: begin
              src_nxt         = SRC_OAM;
              sprite_addr_nxt = sprite_addr_r + 8'd1;
            end
            ppurp_pkg::REG_SCROLL: rdata_nxt = scroll_count_r[0] ? horiz_scroll_r
                                                                 : vert_scroll_r;
            ppurp_pkg::REG_VADDR:  rdata_nxt = video_addr_r[7:0];
            ppurp_pkg::REG_VDATA: begin
              if (vaddr_ok) begin
                src_nxt        = SRC_VRAM;
                video_addr_nxt = video_addr_r + vaddr_step;
              end
            end
            default: ;
          endcase
        end
        ppurp_pkg::ACT_VBL:  vblank_nxt = in_flag_in;
        ppurp_pkg::ACT_POLL: begin
          if (ctrl_one_r[7]) begin
            irq_nxt    = vblank_r;
            vblank_nxt = 1'b0;
          end
        end
        ppurp_pkg::ACT_LOAD: begin
          vram_we    = 1'b1;
          vram_waddr = in_load_addr[VA_W-1:0];
        end
        ppurp_pkg::ACT_HIT:  hit_nxt = in_flag_in;
        default: ;
      endcase
    end
  end

  // Video memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (vram_we) begin
      vram_mem[vram_waddr] <= in_wdata;
    end
    vram_q_r <= vram_mem[video_addr_r[VA_W-1:0]];
  end

  // Sprite memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (oam_we) begin
      oam_mem[sprite_addr_r[OA_W-1:0]] <= in_wdata;
    end
    oam_q_r <= oam_mem[sprite_addr_r[OA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_addr_r   <= ppurp_pkg::VADDR_RESET;
      sprite_addr_r  <= 8'd0;
      scroll_count_r <= 8'd0;
      horiz_scroll_r <= 8'd0;
      vert_scroll_r  <= 8'd0;
      ctrl_one_r     <= 8'd0;
      ctrl_two_r     <= 8'd0;
      status_r       <= 8'd0;
      vblank_r       <= 1'b0;
      hit_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      video_addr_r   <= video_addr_nxt;
      sprite_addr_r  <= sprite_addr_nxt;
      scroll_count_r <= scroll_count_nxt;
      horiz_scroll_r <= horiz_scroll_nxt;
      vert_scroll_r  <= vert_scroll_nxt;
      ctrl_one_r     <= ctrl_one_nxt;
      ctrl_two_r     <= ctrl_two_nxt;
      status_r       <= status_nxt;
      vblank_r       <= vblank_nxt;
      hit_r          <= hit_nxt;
      out_valid_r    <= accept;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    rdata_r <= rdata_nxt;
    irq_r   <= irq_nxt;
    src_r   <= src_nxt;
  end

  always_comb begin
    unique case (src_r)
      SRC_VRAM: out_rdata = vram_q_r;
      SRC_OAM:  out_rdata = oam_q_r;
      default:  out_rdata = rdata_r;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_irq_pending = irq_r;

endmodule

/* rtl/core/ppurp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPU register port checker
// Port-level checks on result timing and on which actions may return data.
// ----------------------------------------------------------------------------
module ppurp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_action,
  input logic       out_valid,
  input logic [7:0] out_rdata,
  input logic       out_irq_pending
);

  // Every accepted item gives its result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted item gave no result in the next cycle");

  // No result appears without an item accepted the cycle before.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result shown without an accepted item");

  // Only a vblank poll can raise the interrupt flag.
  a_irq_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq_pending) |-> ($past(in_action) == ppurp_pkg::ACT_POLL))
    else $error("interrupt flag raised by an item that is not a poll");

  // Only a register read returns a nonzero byte.
  a_rdata_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rdata != 8'd0) |-> ($past(in_action) == ppurp_pkg::ACT_READ))
    else $error("nonzero read byte for an item that is not a read");

endmodule

bind ppu_cpu_register_port ppurp_checker u_ppurp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_rdata       (out_rdata),
  .out_irq_pending (out_irq_pending)
);
